>>> rtl/core/gfb_pkg.sv
`default_nettype none

package gfb_pkg;

  localparam int unsigned STORE_ROWS         = 64;
  localparam int unsigned STORE_BYTE_COLUMNS = 128;
  localparam int unsigned CFG_DATA_W         = 9;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_MONO    = 2'd1,
    OP_GRAY    = 2'd2,
    OP_REFRESH = 2'd3
  } gfb_op_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_COLUMN = 2'd0,
    CFG_ORIGIN_ROW    = 2'd1,
    CFG_IMAGE_WIDTH   = 2'd2,
    CFG_IMAGE_HEIGHT  = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_RESULT
  } gfb_state_e;

  typedef struct packed {
    gfb_op_e    cmd;
    logic [7:0] image_byte;
    logic       first_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       end_of_frame;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       clr_en;
    logic       img_load;
    logic       img_mono;
    logic       wr_en;
    logic [1:0] wr_k;
    logic       wr_mono;
    logic       scan_load;
    logic       out_load;
  } gfb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
  } gfb_status_t;

endpackage

`default_nettype wire

>>> rtl/core/gfb_ctrl.sv
`default_nettype none

module gfb_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  gfb_pkg::gfb_op_e    in_op_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  gfb_pkg::gfb_status_t status_i,
  output gfb_pkg::gfb_cmd_t   cmd_o
);
  import gfb_pkg::*;

  gfb_state_e state_q, state_d;
  logic [1:0] wr_k_q, wr_k_d;
  logic       mono_q, mono_d;
  logic       out_valid_q, out_valid_d;
  logic       wr_last;
  logic       slot_free;

  assign wr_last   = !mono_q || (wr_k_q == 2'd3);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i) inside
            OP_CLEAR:           state_d = ST_CLEAR;
            OP_MONO, OP_GRAY:   state_d = ST_WRITE;
            OP_REFRESH:         state_d = ST_RESULT;
          endcase
        end
      end
      ST_WRITE: begin
        if (wr_last) state_d = ST_IDLE;
      end
      ST_RESULT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.img_load  = in_valid_i && (in_op_i == OP_MONO || in_op_i == OP_GRAY);
        cmd_o.img_mono  = (in_op_i == OP_MONO);
        cmd_o.scan_load = in_valid_i && (in_op_i == OP_REFRESH);
      end
      ST_WRITE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_k    = wr_k_q;
        cmd_o.wr_mono = mono_q;
      end
      ST_RESULT: begin
        cmd_o.out_load = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_k_d = wr_k_q;
    mono_d = mono_q;
    if (cmd_o.img_load) begin
      wr_k_d = 2'd0;
      mono_d = cmd_o.img_mono;
    end else if (cmd_o.wr_en) begin
      wr_k_d = wr_k_q + 2'd1;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wr_k_q      <= 2'd0;
      mono_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_k_q      <= wr_k_d;
      mono_q      <= mono_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // the frame store never sees a write and a read together
  a_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cmd_o.wr_en || cmd_o.clr_en) && cmd_o.scan_load))
    else $error("memory write and read in the same cycle");

  a_refresh_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_op_i == OP_REFRESH) |=> (state_q == ST_RESULT))
    else $error("refresh word did not reach result state");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_gray_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && !mono_q) |-> (wr_k_q == 2'd0))
    else $error("gray word took more than one write");

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("input taken during clearing pass");

endmodule

`default_nettype wire

>>> rtl/core/gfb_datapath.sv
`default_nettype none

module gfb_datapath #(
  parameter int unsigned StoreRows        = gfb_pkg::STORE_ROWS,
  parameter int unsigned StoreByteColumns = gfb_pkg::STORE_BYTE_COLUMNS
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  input  gfb_pkg::cfg_index_e              cfg_index_i,
  input  wire [gfb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  gfb_pkg::in_item_t                in_i,
  input  gfb_pkg::gfb_cmd_t                cmd_i,
  output gfb_pkg::gfb_status_t             status_o,
  output gfb_pkg::out_item_t               out_o
);
  import gfb_pkg::*;

  localparam int unsigned Depth    = StoreRows * StoreByteColumns;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned RowW     = (StoreRows > 1) ? $clog2(StoreRows) : 1;
  localparam int unsigned ColW     = $clog2(StoreByteColumns);
  localparam int unsigned StepW    = $clog2(StoreByteColumns + 4);
  localparam int unsigned StepLast = StoreByteColumns + 3;
  localparam int unsigned NumHdr   = 4;

  localparam logic [7:0] HdrPage   = 8'hB0;
  localparam logic [7:0] HdrColHi  = 8'h10;
  localparam logic [7:0] HdrColLo  = 8'h00;

  function automatic logic [7:0] pair_byte(input logic [1:0] pair);
    logic [7:0] v;
    case (pair)
      2'b11:   v = 8'hFF;
      2'b10:   v = 8'hF0;
      2'b01:   v = 8'h0F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // configuration
  logic [7:0] origin_col_q;
  logic [5:0] origin_row_q;
  logic [8:0] width_q;
  logic [6:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= 8'd0;
      origin_row_q <= 6'd0;
      width_q      <= 9'd8;
      height_q     <= 7'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_COLUMN: origin_col_q <= cfg_data_i[7:0];
        CFG_ORIGIN_ROW:    origin_row_q <= cfg_data_i[5:0];
        CFG_IMAGE_WIDTH:   width_q      <= cfg_data_i[8:0];
        CFG_IMAGE_HEIGHT:  height_q     <= cfg_data_i[6:0];
      endcase
    end
  end

  // image position
  logic [6:0] row_pos_q, row_pos_d;
  logic [6:0] byte_pos_q, byte_pos_d;
  logic [8:0] width_eff;
  logic [9:0] width_round;
  logic [7:0] bpr;
  logic [6:0] rp, bp;
  logic [7:0] bp_inc;
  logic       skip, wrap;

  logic [7:0] wr_row_q;
  logic [9:0] wr_col_q;
  logic       wr_skip_q;
  logic [7:0] wr_byte_q;

  always_comb begin
    width_eff   = width_q[8] ? 9'd256 : width_q;
    width_round = 10'(width_eff) + 10'd7;
    bpr         = cmd_i.img_mono ? 8'(width_round[9:3]) : width_eff[8:1];
    rp          = in_i.first_of_image ? 7'd0 : row_pos_q;
    bp          = in_i.first_of_image ? 7'd0 : byte_pos_q;
    skip        = (bpr == 8'd0) || (rp >= height_q);
    bp_inc      = 8'(bp) + 8'd1;
    wrap        = (bp_inc >= bpr);
    row_pos_d   = rp;
    byte_pos_d  = bp;
    if (!skip) begin
      if (wrap) begin
        byte_pos_d = 7'd0;
        row_pos_d  = rp + 7'd1;
      end else begin
        byte_pos_d = bp_inc[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q  <= 7'd0;
      byte_pos_q <= 7'd0;
    end else if (cmd_i.img_load) begin
      row_pos_q  <= row_pos_d;
      byte_pos_q <= byte_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.img_load) begin
      wr_row_q  <= 8'(origin_row_q) + 8'(rp);
      wr_col_q  <= 10'(origin_col_q[7:1])
                 + (cmd_i.img_mono ? {1'b0, bp, 2'b00} : 10'(bp));
      wr_skip_q <= skip;
      wr_byte_q <= in_i.image_byte;
    end
  end

  // store write side
  logic [9:0]       col_k;
  logic             wr_ok;
  logic [1:0]       pair;
  logic [7:0]       wr_data;
  logic [AddrW-1:0] img_addr;
  logic [AddrW-1:0] clr_cnt_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  always_comb begin
    col_k = wr_col_q + 10'(cmd_i.wr_k);
    wr_ok = !wr_skip_q && ({1'b0, wr_row_q} < 9'(StoreRows))
            && (col_k < 10'(StoreByteColumns));
    case (cmd_i.wr_k)
      2'd0:    pair = wr_byte_q[7:6];
      2'd1:    pair = wr_byte_q[5:4];
      2'd2:    pair = wr_byte_q[3:2];
      default: pair = wr_byte_q[1:0];
    endcase
    wr_data  = cmd_i.wr_mono ? pair_byte(pair) : wr_byte_q;
    img_addr = AddrW'(wr_row_q[RowW-1:0]) * AddrW'(StoreByteColumns)
             + AddrW'(col_k[ColW-1:0]);
    mem_we    = cmd_i.clr_en || (cmd_i.wr_en && wr_ok);
    mem_waddr = cmd_i.clr_en ? clr_cnt_q : img_addr;
    mem_wdata = cmd_i.clr_en ? 8'h00 : wr_data;
  end

  assign status_o.clr_last = (clr_cnt_q == AddrW'(Depth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + AddrW'(1);
    end
  end

  // refresh scan
  logic [RowW-1:0]  scan_row_q;
  logic [StepW-1:0] scan_step_q;
  logic [StepW-1:0] data_col;
  logic             is_hdr;
  logic             step_wrap, row_wrap;
  logic [7:0]       hdr_val;
  logic [AddrW-1:0] mem_raddr;
  logic             mem_re;
  logic             rf_is_cmd_q;
  logic [7:0]       rf_val_q;
  logic             rf_eof_q;

  always_comb begin
    is_hdr    = (scan_step_q < StepW'(NumHdr));
    data_col  = scan_step_q - StepW'(NumHdr);
    step_wrap = (scan_step_q == StepW'(StepLast));
    row_wrap  = (scan_row_q == RowW'(StoreRows - 1));
    if (scan_step_q == StepW'(0)) begin
      hdr_val = HdrPage;
    end else if (scan_step_q == StepW'(1)) begin
      hdr_val = 8'(scan_row_q);
    end else if (scan_step_q == StepW'(2)) begin
      hdr_val = HdrColHi;
    end else begin
      hdr_val = HdrColLo;
    end
    mem_re    = cmd_i.scan_load && !is_hdr;
    mem_raddr = AddrW'(scan_row_q) * AddrW'(StoreByteColumns)
              + AddrW'(data_col[ColW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q  <= '0;
      scan_step_q <= '0;
    end else if (cmd_i.scan_load) begin
      if (step_wrap) begin
        scan_step_q <= '0;
        scan_row_q  <= row_wrap ? '0 : scan_row_q + RowW'(1);
      end else begin
        scan_step_q <= scan_step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_load) begin
      rf_is_cmd_q <= is_hdr;
      rf_val_q    <= hdr_val;
      rf_eof_q    <= step_wrap && row_wrap;
    end
  end

  // frame store
  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // result register
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_byte     <= rf_is_cmd_q ? rf_val_q : rd_q;
      out_q.is_command   <= rf_is_cmd_q;
      out_q.end_of_frame <= rf_eof_q;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

>>> rtl/core/gray_frame_blit_and_refresh.sv
`default_nettype none

// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    in_i  (cmd, image_byte, first_of_image)
// out       out_valid_o / out_ready_i  out_o (out_byte, is_command, end_of_frame)
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A mono word is accepted and then written as four store bytes through the single
// store write port, a gray word as one; a refresh word may wait on out_ready_i.
// A clear word and reset both start a clearing pass over all StoreRows*StoreByteColumns
// store bytes (8192 at defaults), one store byte per cycle; in_ready_o stays low meanwhile.
// The result register holds one word; a stalled output only delays the next refresh.
// Configuration writes are taken in any cycle.

module gray_frame_blit_and_refresh #(
  parameter int unsigned StoreRows        = gfb_pkg::STORE_ROWS,
  parameter int unsigned StoreByteColumns = gfb_pkg::STORE_BYTE_COLUMNS
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  gfb_pkg::in_item_t             in_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output gfb_pkg::out_item_t            out_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  gfb_pkg::cfg_index_e           cfg_index_i,
  input  wire [gfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gfb_pkg::*;

  gfb_cmd_t    cmd;
  gfb_status_t status;

  assign cfg_ready_o = 1'b1;

  gfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gfb_datapath #(
    .StoreRows        (StoreRows),
    .StoreByteColumns (StoreByteColumns)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> tb/gray_frame_blit_and_refresh_tb.sv
`timescale 1ns / 1ps

module gray_frame_blit_and_refresh_tb;
  import gfb_pkg::*;

  localparam int unsigned STORE_BYTES     = STORE_ROWS * STORE_BYTE_COLUMNS;
  localparam int unsigned ROW_HEADER      = 4;
  localparam int unsigned ROW_SWEEP_WORDS = STORE_BYTE_COLUMNS + 2 * ROW_HEADER;
  localparam int unsigned RANDOM_WORDS    = 1200;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam logic [7:0]  PAGE_ADDR_CMD   = 8'hB0;
  localparam logic [7:0]  COL_HIGH_CMD    = 8'h10;
  localparam logic [7:0]  COL_LOW_CMD     = 8'h00;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_e            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gray_frame_blit_and_refresh i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Frame store and position model
  logic [7:0]  frame_bytes [STORE_BYTES];
  int unsigned blit_row;
  int unsigned blit_byte;
  int unsigned scan_row;
  int unsigned scan_step;
  logic [7:0]  org_col;
  logic [5:0]  org_row;
  logic [8:0]  img_width;
  logic [6:0]  img_height;

  out_item_t   panel_bytes_due [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned no_gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void clear_frame();
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
  endfunction

  function automatic void put_frame_byte(int unsigned row, int unsigned col, logic [7:0] b);
    // drop writes outside the store
    if (row < STORE_ROWS && col < STORE_BYTE_COLUMNS)
      frame_bytes[row * STORE_BYTE_COLUMNS + col] = b;
  endfunction

  function automatic void blit_image_byte(logic mono, logic [7:0] b, logic first);
    int unsigned w;
    int unsigned per_row;
    int unsigned row;
    int unsigned col;
    logic [1:0]  pair;
    w = (img_width > 256) ? 256 : img_width;
    per_row = mono ? (w + 7) / 8 : w / 2;
    if (first) begin
      blit_row  = 0;
      blit_byte = 0;
    end
    if (per_row == 0 || blit_row >= img_height) return;
    row = org_row + blit_row;
    if (mono) begin
      col = org_col / 2 + blit_byte * 4;
      for (int k = 0; k < 4; k++) begin
        pair = b[7 - 2 * k -: 2];
        put_frame_byte(row, col + k, {{4{pair[1]}}, {4{pair[0]}}});
      end
    end else begin
      put_frame_byte(row, org_col / 2 + blit_byte, b);
    end
    blit_byte++;
    if (blit_byte >= per_row) begin
      blit_byte = 0;
      blit_row++;
    end
  endfunction

  function automatic out_item_t next_panel_byte();
    out_item_t o;
    o.is_command   = 1'b1;
    o.end_of_frame = 1'b0;
    case (scan_step)
      0:       o.out_byte = PAGE_ADDR_CMD;
      1:       o.out_byte = scan_row[7:0];
      2:       o.out_byte = COL_HIGH_CMD;
      3:       o.out_byte = COL_LOW_CMD;
      default: begin
        o.is_command = 1'b0;
        o.out_byte   = frame_bytes[scan_row * STORE_BYTE_COLUMNS + scan_step - ROW_HEADER];
      end
    endcase
    scan_step++;
    if (scan_step >= ROW_HEADER + STORE_BYTE_COLUMNS) begin
      scan_step = 0;
      scan_row++;
      if (scan_row >= STORE_ROWS) begin
        scan_row       = 0;
        o.end_of_frame = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic void advance_frame_model(in_item_t w);
    case (w.cmd)
      OP_CLEAR:   clear_frame();
      OP_MONO:    blit_image_byte(1'b1, w.image_byte, w.first_of_image);
      OP_GRAY:    blit_image_byte(1'b0, w.image_byte, w.first_of_image);
      OP_REFRESH: panel_bytes_due.push_back(next_panel_byte());
      default:    ;
    endcase
  endfunction

  function automatic in_item_t make_word(gfb_op_e op, logic [7:0] b, logic first);
    in_item_t w;
    w.cmd            = op;
    w.image_byte     = b;
    w.first_of_image = first;
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Leave valid high after acceptance; the next call either drops it or replaces the word.
  task automatic send_word(in_item_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    advance_frame_model(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (panel_bytes_due.size() != 0) @(posedge clk);
    // let a trailing image write or clear finish
    repeat (8) @(posedge clk);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_register(cfg_index_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_COLUMN: org_col    = value[7:0];
      CFG_ORIGIN_ROW:    org_row    = value[5:0];
      CFG_IMAGE_WIDTH:   img_width  = value[8:0];
      CFG_IMAGE_HEIGHT:  img_height = value[6:0];
      default:           ;
    endcase
  endtask

  task automatic set_geometry(logic [8:0] col, logic [8:0] row, logic [8:0] w, logic [8:0] h);
    write_register(CFG_ORIGIN_COLUMN, col);
    write_register(CFG_ORIGIN_ROW, row);
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_refresh(int unsigned count);
    repeat (count)
      send_word(make_word(OP_REFRESH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  // Reset geometry: bit-pair expansion, gray pass-through, mixed kinds, clear
  task automatic test_blit_defaults();
    wait_idle();
    send_word(make_word(OP_MONO, 8'hE4, 1'b1));
    send_word(make_word(OP_MONO, 8'h1B, 1'b0));
    send_word(make_word(OP_MONO, 8'hFF, 1'b0));
    send_word(make_word(OP_MONO, 8'h00, 1'b0));
    send_word(make_word(OP_GRAY, 8'hA5, 1'b1));
    send_word(make_word(OP_GRAY, 8'h5A, 1'b0));
    send_word(make_word(OP_MONO, 8'h9C, 1'b0));
    send_refresh(16);
    send_word(make_word(OP_CLEAR, 8'hFF, 1'b1));
    send_word(make_word(OP_MONO, 8'hFF, 1'b0));
    send_word(make_word(OP_REFRESH, 8'hFF, 1'b1));
    send_refresh(4);
  endtask

  // Store edges, zero bytes per row, oversized width, zero and exhausted height
  task automatic test_geometry_extremes();
    wait_idle();
    set_geometry(9'h1FF, 9'h1FF, 9'h100, 9'h1C0);
    send_word(make_word(OP_MONO, 8'hFF, 1'b1));
    send_word(make_word(OP_GRAY, 8'h77, 1'b0));
    send_word(make_word(OP_GRAY, 8'h77, 1'b1));
    wait_idle();
    set_geometry(9'h000, 9'h000, 9'h000, 9'h07F);
    send_word(make_word(OP_MONO, 8'hAA, 1'b1));
    send_word(make_word(OP_GRAY, 8'h55, 1'b0));
    wait_idle();
    set_geometry(9'h002, 9'h000, 9'h001, 9'h040);
    send_word(make_word(OP_GRAY, 8'h33, 1'b1));
    send_word(make_word(OP_MONO, 8'h6C, 1'b0));
    wait_idle();
    set_geometry(9'h000, 9'h001, 9'h1FF, 9'h000);
    send_word(make_word(OP_MONO, 8'hFF, 1'b1));
    wait_idle();
    set_geometry(9'h000, 9'h002, 9'h002, 9'h001);
    send_word(make_word(OP_MONO, 8'hC3, 1'b1));
    send_word(make_word(OP_MONO, 8'h3C, 1'b0));
    send_word(make_word(OP_GRAY, 8'h81, 1'b0));
    send_refresh(4);
  endtask

  task automatic test_random_blits();
    int unsigned sent;
    int unsigned r;
    logic [8:0]  w;
    logic [8:0]  h;
    gfb_op_e     kind;
    gfb_op_e     other;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      r = $urandom_range(0, 9);
      if (r == 0)      w = 9'd0;
      else if (r == 1) w = 9'd1;
      else if (r == 2) w = 9'd256;
      else if (r == 3) w = 9'($urandom_range(257, 511));
      else             w = 9'($urandom_range(2, 64));
      r = $urandom_range(0, 9);
      if (r == 0)      h = 9'd0;
      else if (r == 1) h = 9'($urandom_range(65, 511));
      else             h = 9'($urandom_range(1, 24));
      set_geometry(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), w, h);
      repeat ($urandom_range(4, 10)) begin
        kind  = $urandom_range(0, 1) ? OP_MONO : OP_GRAY;
        other = (kind == OP_MONO) ? OP_GRAY : OP_MONO;
        send_word(make_word(kind, 8'($urandom_range(0, 255)), 1'b1));
        sent++;
        repeat ($urandom_range(1, 48)) begin
          r = $urandom_range(0, 199);
          if (r < 2)
            send_word(make_word(OP_CLEAR, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
          else if (r < 40)
            send_refresh(1);
          else if (r < 50)
            send_word(make_word(other, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
          else if (r < 56)
            send_word(make_word(kind, 8'($urandom_range(0, 255)), 1'b1));
          else
            send_word(make_word(kind, 8'($urandom_range(0, 255)), 1'b0));
          sent++;
        end
      end
    end
  endtask

  // Read a full store row back and step into the next row
  task automatic test_frame_sweep();
    wait_idle();
    send_refresh(ROW_SWEEP_WORDS);
  endtask

  initial begin
    int unsigned hold;
    logic        rdy;
    hold = 0;
    rdy  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold = $urandom_range(0, 9);
        if (hold < 6) begin
          rdy  = 1'b1;
          hold = $urandom_range(1, 24);
        end else if (hold < 9) begin
          rdy  = 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          rdy  = 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
      out_ready <= rdy;
      hold--;
    end
  end

  always @(posedge clk) begin : check_panel_bytes
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (panel_bytes_due.size() == 0) begin
        $error("output word with none expected");
        mismatches++;
      end else begin
        want = panel_bytes_due.pop_front();
        if (out_word.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_word.out_byte);
          mismatches++;
        end
        if (out_word.is_command !== want.is_command) begin
          $error("is_command: expected %0d, got %0d", want.is_command, out_word.is_command);
          mismatches++;
        end
        if (out_word.end_of_frame !== want.end_of_frame) begin
          $error("end_of_frame: expected %0d, got %0d", want.end_of_frame,
                 out_word.end_of_frame);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= make_word(OP_CLEAR, 8'h00, 1'b0);
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ORIGIN_COLUMN;
    cfg_data  <= '0;
    clear_frame();
    blit_row   = 0;
    blit_byte  = 0;
    scan_row   = 0;
    scan_step  = 0;
    org_col    = 8'd0;
    org_row    = 6'd0;
    img_width  = 9'd8;
    img_height = 7'd16;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_blit_defaults();
    test_geometry_extremes();
    test_random_blits();
    test_frame_sweep();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
